[src/ascc_pkg.sv]
// Shared types, constants and helper functions of the ADC slice channel compressor.
package ascc_pkg;

  // Fixed field geometry
  localparam int NumSamples = 5;
  localparam int NumDiffs   = 4;
  localparam int SampleW    = 10;
  localparam int WidthW     = 4;
  localparam int FmtW       = 3;
  localparam int PosW       = 3;
  localparam int DiffIdxW   = $clog2(NumDiffs);

  // Lookup field limits and defaults
  localparam int LutBitsDef = 8;
  localparam int TagBitsDef = 3;
  localparam int LutBitsMax = 10;
  localparam int TagBitsMax = 4;

  // Descriptor queue depth
  localparam int QueueDepthDef = 4;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PEDESTAL   = 3'd0,
    REG_WIN_BELOW  = 3'd1,
    REG_WIN_ABOVE  = 3'd2,
    REG_PEAK_TAG   = 3'd3,
    REG_TRIG_SLICE = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [9:0] PedestalRst  = 10'd32;
  localparam logic [3:0] WinBelowRst  = 4'd4;
  localparam logic [3:0] WinAboveRst  = 4'd11;
  localparam logic [2:0] PeakTagRst   = 3'd4;
  localparam logic [2:0] TrigSliceRst = 3'd2;

  // Format codes
  localparam logic [FmtW-1:0] FMT_SHORT2 = 3'd0;
  localparam logic [FmtW-1:0] FMT_SHORT3 = 3'd1;
  localparam logic [FmtW-1:0] FMT_LUT3   = 3'd2;
  localparam logic [FmtW-1:0] FMT_FULL6  = 3'd3;
  localparam logic [FmtW-1:0] FMT_FULL8  = 3'd4;
  localparam logic [FmtW-1:0] FMT_FULL10 = 3'd5;

  // Header offsets added to the minimum position
  localparam logic [WidthW-1:0] HdrShort3Off = 4'd5;
  localparam logic [WidthW-1:0] HdrLongOff   = 4'd10;

  typedef struct packed {
    logic [9:0] pedestal;
    logic [3:0] win_below;
    logic [3:0] win_above;
    logic [2:0] peak_tag;
    logic [2:0] trig_slice;
  } cfg_t;

  // One classified channel, handed from the front end to the token sequencer
  typedef struct packed {
    logic [FmtW-1:0]                    fmt;
    logic [WidthW-1:0]                  hdr;
    logic [WidthW-1:0]                  dw;
    logic [3:0]                         off;
    logic [SampleW-1:0]                 minv;
    logic [NumDiffs-1:0][SampleW-1:0]   diff;
    logic [NumDiffs-1:0]                dlong;
    logic [LutBitsMax-1:0]              lut;
    logic [TagBitsMax-1:0]              tag;
    logic                               any_lut;
    logic                               anytag;
    logic [NumDiffs-1:0]                tbits;
    logic                               inwin;
  } desc_t;

  typedef enum logic [3:0] {
    ST_HDR,
    ST_FMT,
    ST_LFLAG,
    ST_TFLAG,
    ST_LUTV,
    ST_LUTT,
    ST_TBIT,
    ST_MFLAG,
    ST_MIN,
    ST_DFLAG,
    ST_DIFF
  } tok_state_t;

  // Number of bits needed to hold x, zero for zero.
  function automatic logic [WidthW-1:0] minbits(input logic [SampleW-1:0] x);
    logic [WidthW-1:0] n;
    n = '0;
    for (int i = 0; i < SampleW; i++) begin
      if (x[i]) begin
        n = WidthW'(i + 1);
      end
    end
    return n;
  endfunction

  // Keep only the low w bits of v.
  function automatic logic [SampleW-1:0] mask_field(input logic [SampleW-1:0] v,
                                                     input logic [WidthW-1:0] w);
    logic [SampleW-1:0] m;
    for (int i = 0; i < SampleW; i++) begin
      m[i] = (WidthW'(i) < w);
    end
    return v & m;
  endfunction

endpackage

[src/ascc_front.sv]
// Front end: accepts channels, finds the minimum, classifies and builds a descriptor.
module ascc_front #(
  parameter int LUT_BITS = ascc_pkg::LutBitsDef,
  parameter int TAG_BITS = ascc_pkg::TagBitsDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ascc_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [LUT_BITS-1:0]                 in_lut_value,
  input  logic [TAG_BITS-1:0]                 in_lut_tag,
  input  logic [ascc_pkg::SampleW-1:0]        in_sample_0,
  input  logic [ascc_pkg::SampleW-1:0]        in_sample_1,
  input  logic [ascc_pkg::SampleW-1:0]        in_sample_2,
  input  logic [ascc_pkg::SampleW-1:0]        in_sample_3,
  input  logic [ascc_pkg::SampleW-1:0]        in_sample_4,
  input  logic [ascc_pkg::NumSamples-1:0]     in_sample_tag_mask,
  output logic                                q_push,
  output ascc_pkg::desc_t                     q_desc,
  input  logic                                q_full
);

  localparam int SW = ascc_pkg::SampleW;
  localparam int PW = ascc_pkg::PosW;
  localparam int WW = ascc_pkg::WidthW;
  localparam int ND = ascc_pkg::NumDiffs;
  localparam int NS = ascc_pkg::NumSamples;
  localparam int TagCmpW = (TAG_BITS > 3) ? TAG_BITS : 3;

  // Stage A inputs
  logic [SW-1:0] smp [NS];
  logic [SW-1:0] m01, m23, m03, min_a;
  logic [PW-1:0] p01, p23, p03, pos_a;
  logic [PW-1:0] trig;
  logic [ND-1:0] tbits_a;
  logic          a_load;

  // Stage A registers
  logic          a_valid_r, a_valid_nxt;
  logic [SW-1:0] a_smp_r [NS];
  logic [SW-1:0] a_minv_r;
  logic [PW-1:0] a_pos_r;
  logic [LUT_BITS-1:0] a_lut_r;
  logic [TAG_BITS-1:0] a_tag_r;
  logic [ND-1:0] a_tbits_r;

  // Stage B signals
  logic [SW-1:0] dfull [NS];
  logic [SW-1:0] dc [ND];
  logic [SW-1:0] dor;
  logic [WW-1:0] maxlen, wide_len;
  logic signed [11:0] lo_s, hi_s, mv_s;
  logic          inwin;
  logic [SW-1:0] off_sum;
  logic          lut_zero, tag_zero, lut_small, peak_match, anytag;
  logic          is_short, is_lut3;
  logic [ascc_pkg::FmtW-1:0] wide_fmt;

  assign smp[0] = in_sample_0;
  assign smp[1] = in_sample_1;
  assign smp[2] = in_sample_2;
  assign smp[3] = in_sample_3;
  assign smp[4] = in_sample_4;

  // Minimum search as a tree; strict compares keep the earliest sample on a tie.
  always_comb begin
    if (smp[1] < smp[0]) begin
      m01 = smp[1];
      p01 = PW'(1);
    end else begin
      m01 = smp[0];
      p01 = PW'(0);
    end
    if (smp[3] < smp[2]) begin
      m23 = smp[3];
      p23 = PW'(3);
    end else begin
      m23 = smp[2];
      p23 = PW'(2);
    end
    if (m23 < m01) begin
      m03 = m23;
      p03 = p23;
    end else begin
      m03 = m01;
      p03 = p01;
    end
    if (smp[4] < m03) begin
      min_a = smp[4];
      pos_a = PW'(4);
    end else begin
      min_a = m03;
      pos_a = p03;
    end
  end

  // Sample tag bits with the trigger slice removed; out-of-range slices saturate.
  assign trig = (cfg.trig_slice > PW'(NS - 1)) ? PW'(NS - 1) : cfg.trig_slice;

  always_comb begin
    for (int j = 0; j < ND; j++) begin
      tbits_a[j] = (PW'(j) < trig) ? in_sample_tag_mask[j] : in_sample_tag_mask[j + 1];
    end
  end

  // Stage A handshake: the stage empties into the queue when there is room.
  assign in_ready = !a_valid_r || !q_full;
  assign a_load   = in_valid && in_ready;
  assign q_push   = a_valid_r && !q_full;

  always_comb begin
    if (a_load) begin
      a_valid_nxt = 1'b1;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      for (int i = 0; i < NS; i++) begin
        a_smp_r[i] <= smp[i];
      end
      a_minv_r  <= min_a;
      a_pos_r   <= pos_a;
      a_lut_r   <= in_lut_value;
      a_tag_r   <= in_lut_tag;
      a_tbits_r <= tbits_a;
    end
  end

  // Differences to the minimum, packed down to the four samples that are not it.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      dfull[i] = a_smp_r[i] - a_minv_r;
    end
    dor = '0;
    for (int k = 0; k < ND; k++) begin
      dc[k] = (PW'(k) < a_pos_r) ? dfull[k] : dfull[k + 1];
      dor   = dor | dc[k];
    end
  end

  // The widest difference has the same bit length as the OR of all of them.
  assign maxlen = ascc_pkg::minbits(dor);

  // Pedestal window check on the minimum.
  assign lo_s    = $signed(12'(cfg.pedestal) - 12'(cfg.win_below));
  assign hi_s    = $signed(12'(cfg.pedestal) + 12'(cfg.win_above));
  assign mv_s    = $signed(12'(a_minv_r));
  assign inwin   = (mv_s >= lo_s) && (mv_s <= hi_s);
  assign off_sum = a_minv_r - cfg.pedestal + SW'(cfg.win_below);

  // Format decision.
  assign anytag     = |a_tbits_r;
  assign lut_zero   = (a_lut_r == '0);
  assign tag_zero   = (a_tag_r == '0);
  assign lut_small  = (a_lut_r[LUT_BITS-1:3] == '0);
  assign peak_match = (TagCmpW'(a_tag_r) == TagCmpW'(cfg.peak_tag));
  assign is_short   = lut_zero && tag_zero && !anytag && inwin && (maxlen < WW'(4));
  assign is_lut3    = lut_small && ((lut_zero && tag_zero) || (!lut_zero && peak_match)) &&
                      !anytag && inwin && (maxlen <= WW'(4));
  assign wide_len   = inwin ? maxlen : ascc_pkg::minbits(dor | a_minv_r);

  always_comb begin
    if (wide_len <= WW'(6)) begin
      wide_fmt = ascc_pkg::FMT_FULL6;
    end else if (wide_len <= WW'(8)) begin
      wide_fmt = ascc_pkg::FMT_FULL8;
    end else begin
      wide_fmt = ascc_pkg::FMT_FULL10;
    end
  end

  // Descriptor assembly.
  always_comb begin
    q_desc.off     = off_sum[3:0];
    q_desc.minv    = a_minv_r;
    q_desc.lut     = ascc_pkg::LutBitsMax'(a_lut_r);
    q_desc.tag     = ascc_pkg::TagBitsMax'(a_tag_r);
    q_desc.any_lut = !(lut_zero && tag_zero);
    q_desc.anytag  = anytag;
    q_desc.tbits   = a_tbits_r;
    q_desc.inwin   = inwin;
    for (int k = 0; k < ND; k++) begin
      q_desc.diff[k]  = dc[k];
      q_desc.dlong[k] = (dc[k][SW-1:4] != '0);
    end
    if (is_short) begin
      if (maxlen == WW'(3)) begin
        q_desc.fmt = ascc_pkg::FMT_SHORT3;
        q_desc.dw  = WW'(3);
        q_desc.hdr = WW'(a_pos_r) + ascc_pkg::HdrShort3Off;
      end else begin
        q_desc.fmt = ascc_pkg::FMT_SHORT2;
        q_desc.dw  = WW'(2);
        q_desc.hdr = WW'(a_pos_r);
      end
    end else if (is_lut3) begin
      q_desc.fmt = ascc_pkg::FMT_LUT3;
      q_desc.dw  = WW'(4);
      q_desc.hdr = WW'(a_pos_r) + ascc_pkg::HdrLongOff;
    end else begin
      q_desc.fmt = wide_fmt;
      q_desc.dw  = WW'({wide_fmt, 1'b0});
      q_desc.hdr = WW'(a_pos_r) + ascc_pkg::HdrLongOff;
    end
  end

endmodule

[src/ascc_queue.sv]
// Small descriptor queue between the front end and the token sequencer.
module ascc_queue #(
  parameter int DEPTH = ascc_pkg::QueueDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ascc_pkg::desc_t wdata,
  output logic            full,
  input  logic            pop,
  output ascc_pkg::desc_t rdata,
  output logic            empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ascc_pkg::desc_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[src/ascc_back.sv]
// Token sequencer: emits each descriptor's fields, one a cycle unless stalled.
module ascc_back #(
  parameter int LUT_BITS = ascc_pkg::LutBitsDef,
  parameter int TAG_BITS = ascc_pkg::TagBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  ascc_pkg::desc_t               q_desc,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ascc_pkg::SampleW-1:0]  out_field_value,
  output logic [ascc_pkg::WidthW-1:0]   out_field_width,
  output logic                          out_last_field,
  output logic [ascc_pkg::FmtW-1:0]     out_chosen_format
);

  localparam int SW = ascc_pkg::SampleW;
  localparam int WW = ascc_pkg::WidthW;
  localparam int KW = ascc_pkg::DiffIdxW;

  ascc_pkg::tok_state_t st_r, st_nxt, adv_st;
  logic [KW-1:0] k_r, k_nxt, adv_k;

  logic          emit;
  logic [SW-1:0] val;
  logic [WW-1:0] wid;
  logic          last_c;
  logic          is_full_fmt, is_lut3, k_end;

  logic                      out_valid_r, out_valid_nxt;
  logic [SW-1:0]             out_value_r;
  logic [WW-1:0]             out_width_r;
  logic                      out_last_r;
  logic [ascc_pkg::FmtW-1:0] out_fmt_r;

  assign is_full_fmt = (q_desc.fmt >= ascc_pkg::FMT_FULL6);
  assign is_lut3     = (q_desc.fmt == ascc_pkg::FMT_LUT3);
  assign k_end       = (k_r == KW'(ascc_pkg::NumDiffs - 1));

  // A token leaves when a descriptor is waiting and the output register is free.
  assign emit  = !q_empty && (!out_valid_r || out_ready);
  assign q_pop = emit && last_c;

  // Token value, width and successor for the current field.
  always_comb begin
    val    = '0;
    wid    = WW'(1);
    last_c = 1'b0;
    adv_st = st_r;
    adv_k  = k_r;
    case (st_r)
      ascc_pkg::ST_HDR: begin
        val    = SW'(q_desc.hdr);
        wid    = WW'(4);
        adv_k  = '0;
        adv_st = (q_desc.fmt <= ascc_pkg::FMT_SHORT3) ? ascc_pkg::ST_MIN : ascc_pkg::ST_FMT;
      end
      ascc_pkg::ST_FMT: begin
        val    = SW'(q_desc.fmt - ascc_pkg::FMT_LUT3);
        wid    = WW'(2);
        adv_st = ascc_pkg::ST_LFLAG;
      end
      ascc_pkg::ST_LFLAG: begin
        if (is_lut3) begin
          val    = SW'(q_desc.lut != '0);
          adv_st = (q_desc.lut != '0) ? ascc_pkg::ST_LUTV : ascc_pkg::ST_MIN;
        end else begin
          val    = SW'(q_desc.any_lut);
          adv_st = ascc_pkg::ST_TFLAG;
        end
      end
      ascc_pkg::ST_TFLAG: begin
        val = SW'(q_desc.anytag);
        if (q_desc.any_lut) begin
          adv_st = ascc_pkg::ST_LUTV;
        end else if (q_desc.anytag) begin
          adv_st = ascc_pkg::ST_TBIT;
        end else begin
          adv_st = ascc_pkg::ST_MFLAG;
        end
      end
      ascc_pkg::ST_LUTV: begin
        val = SW'(q_desc.lut);
        if (is_lut3) begin
          wid    = WW'(3);
          adv_st = ascc_pkg::ST_MIN;
        end else begin
          wid    = WW'(LUT_BITS);
          adv_st = ascc_pkg::ST_LUTT;
        end
      end
      ascc_pkg::ST_LUTT: begin
        val    = SW'(q_desc.tag);
        wid    = WW'(TAG_BITS);
        adv_st = q_desc.anytag ? ascc_pkg::ST_TBIT : ascc_pkg::ST_MFLAG;
      end
      ascc_pkg::ST_TBIT: begin
        val = SW'(q_desc.tbits[k_r]);
        if (k_end) begin
          adv_k  = '0;
          adv_st = ascc_pkg::ST_MFLAG;
        end else begin
          adv_k = k_r + KW'(1);
        end
      end
      ascc_pkg::ST_MFLAG: begin
        val    = SW'(!q_desc.inwin);
        adv_st = ascc_pkg::ST_MIN;
      end
      ascc_pkg::ST_MIN: begin
        if (is_full_fmt && !q_desc.inwin) begin
          val = q_desc.minv;
          wid = q_desc.dw;
        end else begin
          val = SW'(q_desc.off);
          wid = WW'(4);
        end
        adv_k  = '0;
        adv_st = is_full_fmt ? ascc_pkg::ST_DFLAG : ascc_pkg::ST_DIFF;
      end
      ascc_pkg::ST_DFLAG: begin
        val    = SW'(q_desc.dlong[k_r]);
        adv_st = ascc_pkg::ST_DIFF;
      end
      ascc_pkg::ST_DIFF: begin
        val = q_desc.diff[k_r];
        if (is_full_fmt && !q_desc.dlong[k_r]) begin
          wid = WW'(4);
        end else begin
          wid = q_desc.dw;
        end
        if (k_end) begin
          last_c = 1'b1;
          adv_k  = '0;
          adv_st = ascc_pkg::ST_HDR;
        end else begin
          adv_k  = k_r + KW'(1);
          adv_st = is_full_fmt ? ascc_pkg::ST_DFLAG : ascc_pkg::ST_DIFF;
        end
      end
      default: begin
        adv_k  = '0;
        adv_st = ascc_pkg::ST_HDR;
      end
    endcase
    st_nxt = emit ? adv_st : st_r;
    k_nxt  = emit ? adv_k : k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ascc_pkg::ST_HDR;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
    end
  end

  // Output register: holds a token until the receiver takes it.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= ascc_pkg::mask_field(val, wid);
      out_width_r <= wid;
      out_last_r  <= last_c;
      out_fmt_r   <= q_desc.fmt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_field_value   = out_value_r;
  assign out_field_width   = out_width_r;
  assign out_last_field    = out_last_r;
  assign out_chosen_format = out_fmt_r;

  // The last field of a channel returns the sequencer to the header.
  a_last_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_c) |=> (st_r == ascc_pkg::ST_HDR) && (k_r == '0))
    else $error("sequencer did not return to header after last field");

  // A channel in progress always has its descriptor at the queue head.
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ascc_pkg::ST_HDR) |-> !q_empty)
    else $error("descriptor left the queue in the middle of a channel");

  // Field widths stay within one to ten bits.
  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_width_r != '0) && (out_width_r <= WW'(SW)))
    else $error("field width out of range");

  // Only the six defined formats appear.
  a_fmt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fmt_r <= ascc_pkg::FMT_FULL10))
    else $error("undefined format code on output");

endmodule

[src/adc_slice_channel_compressor_core.sv]
// Top level of the ADC slice channel compressor: configuration registers and the three parts.
//
// Usage:
//   The input channel (in_valid / in_ready) takes one ADC channel per transfer: a lookup
//   word and tag, five 10-bit samples and a per-sample tag mask. The result channel
//   (out_valid / out_ready) delivers the packed fields of that channel as a run of
//   (value, width) tokens, 6 to 20 per channel, with out_last_field on the final one
//   and the selected format on every token.
//   The first token of a channel passes the classification stage, a queue entry and the
//   output register before it is presented, when nothing is queued ahead of it.
//   Throughput: one token per cycle while the receiver takes them; a channel has 6 to 20
//   tokens and the token sequencer sets this rate. The front end takes one channel per
//   cycle until the descriptor queue (QUEUE_DEPTH entries plus one classification stage)
//   is full.
//   When the receiver stalls, the current token stays on the output and the sequencer
//   holds; the front end keeps accepting channels until the queue fills.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata while the block is
//   idle; indexes beyond the register list are ignored.
//   Reset (rst_n low, synchronous) empties the queue and the output register and loads
//   the register defaults.
module adc_slice_channel_compressor_core #(
  parameter int LUT_BITS    = ascc_pkg::LutBitsDef,
  parameter int TAG_BITS    = ascc_pkg::TagBitsDef,
  parameter int QUEUE_DEPTH = ascc_pkg::QueueDepthDef
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ascc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [ascc_pkg::CfgDataW-1:0]      cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [LUT_BITS-1:0]                in_lut_value,
  input  logic [TAG_BITS-1:0]                in_lut_tag,
  input  logic [ascc_pkg::SampleW-1:0]       in_sample_0,
  input  logic [ascc_pkg::SampleW-1:0]       in_sample_1,
  input  logic [ascc_pkg::SampleW-1:0]       in_sample_2,
  input  logic [ascc_pkg::SampleW-1:0]       in_sample_3,
  input  logic [ascc_pkg::SampleW-1:0]       in_sample_4,
  input  logic [ascc_pkg::NumSamples-1:0]    in_sample_tag_mask,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ascc_pkg::SampleW-1:0]       out_field_value,
  output logic [ascc_pkg::WidthW-1:0]        out_field_width,
  output logic                               out_last_field,
  output logic [ascc_pkg::FmtW-1:0]          out_chosen_format
);

  ascc_pkg::cfg_t  cfg_r, cfg_nxt;
  ascc_pkg::desc_t push_desc, head_desc;
  logic            q_push, q_pop, q_full, q_empty;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (ascc_pkg::cfg_reg_t'(cfg_index))
        ascc_pkg::REG_PEDESTAL:   cfg_nxt.pedestal   = cfg_wdata;
        ascc_pkg::REG_WIN_BELOW:  cfg_nxt.win_below  = cfg_wdata[3:0];
        ascc_pkg::REG_WIN_ABOVE:  cfg_nxt.win_above  = cfg_wdata[3:0];
        ascc_pkg::REG_PEAK_TAG:   cfg_nxt.peak_tag   = cfg_wdata[2:0];
        ascc_pkg::REG_TRIG_SLICE: cfg_nxt.trig_slice = cfg_wdata[2:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pedestal   <= ascc_pkg::PedestalRst;
      cfg_r.win_below  <= ascc_pkg::WinBelowRst;
      cfg_r.win_above  <= ascc_pkg::WinAboveRst;
      cfg_r.peak_tag   <= ascc_pkg::PeakTagRst;
      cfg_r.trig_slice <= ascc_pkg::TrigSliceRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: classification.
  ascc_front #(
    .LUT_BITS (LUT_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_lut_value       (in_lut_value),
    .in_lut_tag         (in_lut_tag),
    .in_sample_0        (in_sample_0),
    .in_sample_1        (in_sample_1),
    .in_sample_2        (in_sample_2),
    .in_sample_3        (in_sample_3),
    .in_sample_4        (in_sample_4),
    .in_sample_tag_mask (in_sample_tag_mask),
    .q_push             (q_push),
    .q_desc             (push_desc),
    .q_full             (q_full)
  );

  // Descriptor queue.
  ascc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_desc),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_desc),
    .empty (q_empty)
  );

  // Back end: token sequencing.
  ascc_back #(
    .LUT_BITS (LUT_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_desc            (head_desc),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_field_value   (out_field_value),
    .out_field_width   (out_field_width),
    .out_last_field    (out_last_field),
    .out_chosen_format (out_chosen_format)
  );

endmodule
